[rtl/rcc_pkg.sv]
// ----------------------------------------------------------------------------
// rcc_pkg : ray/circle cast constants, types and helpers
// Field formats, derived internal widths and the output saturation function.
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIR_WIDTH   = FRAC_BITS + 2;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;

    // derived internal widths, sized so nothing wraps
    localparam int V_W    = COORD_WIDTH + 1;              // center - origin
    localparam int VV_W   = 2 * V_W;                      // component square
    localparam int DD_W   = VV_W + 1;                     // |v|^2
    localparam int RR_W   = 2 * RAD_WIDTH;                // r^2
    localparam int PD_W   = V_W + DIR_WIDTH;              // v*dir component
    localparam int DOT_W  = PD_W + 1;                     // v . dir
    localparam int A_W    = DOT_W + 1 - FRAC_BITS;        // rounded projection
    localparam int AA_W   = 2 * A_W;                      // a^2
    localparam int DISC_W = ((AA_W > DD_W) ? AA_W : DD_W) + 2;
    localparam int SQ_N   = A_W;                          // root bits / stages
    localparam int T_W    = A_W + 2;                      // a +/- f
    localparam int M_W    = DIR_WIDTH + T_W;              // dir*t
    localparam int R_W    = M_W + 1 - FRAC_BITS;          // rounded dir*t
    localparam int P_W    = R_W + 1;                      // hit point
    localparam int SAT_W  = P_W + 1;                      // normal

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ox;
        logic signed [COORD_WIDTH-1:0] oy;
        logic signed [DIR_WIDTH-1:0]   dx;
        logic signed [DIR_WIDTH-1:0]   dy;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } t_ray;

    typedef struct packed {
        t_ray                  ray;
        logic signed [A_W-1:0] a;
        logic                  org_in;
        logic                  miss;
        logic [SQ_N+1:0]       rem;
        logic [SQ_N-1:0]       root;
        logic [2*SQ_N-1:0]     xs;
    } t_sq;

    localparam logic signed [SAT_W-1:0] SAT_MAX =
        SAT_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

    function automatic logic signed [COORD_WIDTH-1:0] f_sat(
        input logic signed [SAT_W-1:0] x);
        if (x > SAT_MAX) return SAT_MAX[COORD_WIDTH-1:0];
        if (x < SAT_MIN) return SAT_MIN[COORD_WIDTH-1:0];
        return x[COORD_WIDTH-1:0];
    endfunction

endpackage

[rtl/ray_circle_cast.sv]
// ----------------------------------------------------------------------------
// ray_circle_cast : 2D ray versus circle intersection
// Fully pipelined fixed-point ray cast with a bit-per-stage square root.
// ----------------------------------------------------------------------------
// One ray/circle pair is taken per cycle while o_ready is high, and one result
// comes out per input, in order. Five stages form v, the products, |v|^2, the
// rounded projection a and the discriminant, SQ_N stages resolve one bit each
// of floor(sqrt(disc)), and four stages form t, dir*t, the point and the
// saturated outputs. The square root pipeline is what sets the latency;
// throughput is one transfer per cycle while the output is not stalled. Each
// stage holds only while it is full and the stage after it holds, so bubbles
// are squeezed out and input is still taken while a result waits at the output
// if any stage is empty. A miss returns hit=0 with all other fields zero.
module ray_circle_cast (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [rcc_pkg::COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [rcc_pkg::COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [rcc_pkg::DIR_WIDTH-1:0]   i_dir_x,
    input  logic signed [rcc_pkg::DIR_WIDTH-1:0]   i_dir_y,
    input  logic signed [rcc_pkg::COORD_WIDTH-1:0] i_center_x,
    input  logic signed [rcc_pkg::COORD_WIDTH-1:0] i_center_y,
    input  logic        [rcc_pkg::RAD_WIDTH-1:0]   i_radius,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_hit,
    output logic signed [rcc_pkg::COORD_WIDTH-1:0] o_distance_t,
    output logic signed [rcc_pkg::COORD_WIDTH-1:0] o_point_x,
    output logic signed [rcc_pkg::COORD_WIDTH-1:0] o_point_y,
    output logic signed [rcc_pkg::COORD_WIDTH-1:0] o_normal_x,
    output logic signed [rcc_pkg::COORD_WIDTH-1:0] o_normal_y
);
    import rcc_pkg::*;

    // ---------------- valid bits and stage enables ----------------
    logic            r_v1, r_v2, r_v3, r_v4, r_v5, r_vt, r_vm, r_vp, r_vo;
    logic [SQ_N-1:0] r_vsq;
    logic            en1, en2, en3, en4, en5, ent, enm, enp, eno;
    logic [SQ_N-1:0] ensq;

    // a stage may load when empty or when its contents move on
    assign eno = !r_vo || i_ready;
    assign enp = !r_vp || eno;
    assign enm = !r_vm || enp;
    assign ent = !r_vt || enm;
    always_comb begin
        ensq[SQ_N-1] = !r_vsq[SQ_N-1] || ent;
        for (int k = SQ_N - 2; k >= 0; k--) begin
            ensq[k] = !r_vsq[k] || ensq[k+1];
        end
    end
    assign en5 = !r_v5 || ensq[0];
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            r_vsq <= '0;
            r_vt <= 1'b0; r_vm <= 1'b0; r_vp <= 1'b0; r_vo <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            for (int k = 0; k < SQ_N; k++) begin
                if (ensq[k]) r_vsq[k] <= (k == 0) ? r_v5 : r_vsq[k-1];
            end
            if (ent) r_vt <= r_vsq[SQ_N-1];
            if (enm) r_vm <= r_vt;
            if (enp) r_vp <= r_vm;
            if (eno) r_vo <= r_vp;
        end
    end

    // ---------------- stage 1: capture, v = center - origin ----------------
    t_ray                  r_ray1;
    logic [RAD_WIDTH-1:0]  r_rad1;
    logic signed [V_W-1:0] r_vx1, r_vy1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ray1 <= '{ox: i_origin_x, oy: i_origin_y, dx: i_dir_x, dy: i_dir_y,
                        cx: i_center_x, cy: i_center_y};
            r_rad1 <= i_radius;
            r_vx1  <= V_W'(i_center_x) - V_W'(i_origin_x);
            r_vy1  <= V_W'(i_center_y) - V_W'(i_origin_y);
        end
    end

    // ---------------- stage 2: products ----------------
    t_ray                   r_ray2;
    logic signed [VV_W-1:0] r_vxx2, r_vyy2;
    logic [RR_W-1:0]        r_rr2;
    logic signed [PD_W-1:0] r_pdx2, r_pdy2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_ray2 <= r_ray1;
            r_vxx2 <= r_vx1 * r_vx1;
            r_vyy2 <= r_vy1 * r_vy1;
            r_rr2  <= RR_W'(r_rad1) * RR_W'(r_rad1);
            r_pdx2 <= PD_W'(r_vx1) * PD_W'(r_ray1.dx);
            r_pdy2 <= PD_W'(r_vy1) * PD_W'(r_ray1.dy);
        end
    end

    // ---------------- stage 3: |v|^2 and rounded projection ----------------
    t_ray                    r_ray3;
    logic [RR_W-1:0]         r_rr3;
    logic signed [DD_W-1:0]  r_dd3;
    logic signed [A_W-1:0]   r_a3;
    logic signed [DOT_W:0]   dot_rnd;

    assign dot_rnd = (DOT_W+1)'(r_pdx2) + (DOT_W+1)'(r_pdy2)
                   + (DOT_W+1)'(1 << (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_ray3 <= r_ray2;
            r_rr3  <= r_rr2;
            r_dd3  <= DD_W'(r_vxx2) + DD_W'(r_vyy2);
            r_a3   <= A_W'(dot_rnd >>> FRAC_BITS);
        end
    end

    // ---------------- stage 4: a^2, origin strictly inside test ----------------
    t_ray                    r_ray4;
    logic [RR_W-1:0]         r_rr4;
    logic signed [DD_W-1:0]  r_dd4;
    logic signed [A_W-1:0]   r_a4;
    logic signed [AA_W-1:0]  r_aa4;
    logic                    r_in4;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_ray4 <= r_ray3;
            r_rr4  <= r_rr3;
            r_dd4  <= r_dd3;
            r_a4   <= r_a3;
            r_aa4  <= AA_W'(r_a3) * AA_W'(r_a3);
            r_in4  <= DISC_W'(r_dd3) < $signed(DISC_W'(r_rr3));
        end
    end

    // ---------------- stage 5: discriminant ----------------
    logic signed [DISC_W-1:0] disc;
    t_sq                      r_s5;

    assign disc = $signed(DISC_W'(r_rr4)) + DISC_W'(r_aa4) - DISC_W'(r_dd4);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5.ray    <= r_ray4;
            r_s5.a      <= r_a4;
            r_s5.org_in <= r_in4;
            r_s5.miss   <= disc[DISC_W-1];
            r_s5.rem    <= '0;
            r_s5.root   <= '0;
            r_s5.xs     <= disc[2*SQ_N-1:0];
        end
    end

    // ---------------- square root, one bit per stage ----------------
    t_sq r_sq [SQ_N];
    t_sq n_sq [SQ_N];

    always_comb begin
        for (int k = 0; k < SQ_N; k++) begin
            t_sq             cur;
            logic [SQ_N+1:0] pr;
            logic [SQ_N+1:0] trial;
            cur   = (k == 0) ? r_s5 : r_sq[k-1];
            pr    = {cur.rem[SQ_N-1:0], cur.xs[2*SQ_N-1 -: 2]};
            trial = {cur.root, 2'b01};
            n_sq[k]    = cur;
            n_sq[k].xs = {cur.xs[2*SQ_N-3:0], 2'b00};
            if (pr >= trial) begin
                n_sq[k].rem  = pr - trial;
                n_sq[k].root = {cur.root[SQ_N-2:0], 1'b1};
            end else begin
                n_sq[k].rem  = pr;
                n_sq[k].root = {cur.root[SQ_N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_N; k++) begin
            if (ensq[k]) r_sq[k] <= n_sq[k];
        end
    end

    // ---------------- stage T: t = a +/- f ----------------
    t_sq                   sq_last;
    t_ray                  r_rayt;
    logic                  r_misst;
    logic signed [T_W-1:0] r_t;

    assign sq_last = r_sq[SQ_N-1];

    always_ff @(posedge i_clk) begin
        if (ent) begin
            r_rayt  <= sq_last.ray;
            r_misst <= sq_last.miss;
            if (sq_last.org_in) begin
                r_t <= T_W'(sq_last.a) + $signed(T_W'(sq_last.root));
            end else begin
                r_t <= T_W'(sq_last.a) - $signed(T_W'(sq_last.root));
            end
        end
    end

    // ---------------- stage M: dir * t ----------------
    t_ray                  r_raym;
    logic                  r_missm;
    logic signed [T_W-1:0] r_tm;
    logic signed [M_W-1:0] r_mx, r_my;

    always_ff @(posedge i_clk) begin
        if (enm) begin
            r_raym  <= r_rayt;
            r_missm <= r_misst;
            r_tm    <= r_t;
            r_mx    <= M_W'(r_rayt.dx) * M_W'(r_t);
            r_my    <= M_W'(r_rayt.dy) * M_W'(r_t);
        end
    end

    // ---------------- stage P: point = origin + round(dir*t) ----------------
    logic signed [M_W:0]           mx_rnd, my_rnd;
    logic signed [COORD_WIDTH-1:0] r_cxp, r_cyp;
    logic                          r_missp;
    logic signed [T_W-1:0]         r_tp;
    logic signed [P_W-1:0]         r_px, r_py;

    assign mx_rnd = (M_W+1)'(r_mx) + (M_W+1)'(1 << (FRAC_BITS - 1));
    assign my_rnd = (M_W+1)'(r_my) + (M_W+1)'(1 << (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (enp) begin
            r_cxp   <= r_raym.cx;
            r_cyp   <= r_raym.cy;
            r_missp <= r_missm;
            r_tp    <= r_tm;
            r_px    <= P_W'(r_raym.ox) + P_W'(R_W'(mx_rnd >>> FRAC_BITS));
            r_py    <= P_W'(r_raym.oy) + P_W'(R_W'(my_rnd >>> FRAC_BITS));
        end
    end

    // ---------------- stage O: saturate, zero on miss ----------------
    logic                          r_hit;
    logic signed [COORD_WIDTH-1:0] r_dt, r_opx, r_opy, r_onx, r_ony;

    always_ff @(posedge i_clk) begin
        if (eno) begin
            r_hit <= !r_missp;
            if (r_missp) begin
                r_dt  <= '0;
                r_opx <= '0;
                r_opy <= '0;
                r_onx <= '0;
                r_ony <= '0;
            end else begin
                r_dt  <= f_sat(SAT_W'(r_tp));
                r_opx <= f_sat(SAT_W'(r_px));
                r_opy <= f_sat(SAT_W'(r_py));
                r_onx <= f_sat(SAT_W'(r_px) - SAT_W'(r_cxp));
                r_ony <= f_sat(SAT_W'(r_py) - SAT_W'(r_cyp));
            end
        end
    end

    assign o_valid      = r_vo;
    assign o_hit        = r_hit;
    assign o_distance_t = r_dt;
    assign o_point_x    = r_opx;
    assign o_point_y    = r_opy;
    assign o_normal_x   = r_onx;
    assign o_normal_y   = r_ony;

    // ---------------- assertions ----------------
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_distance_t == 0 && o_point_x == 0 &&
        o_point_y == 0 && o_normal_x == 0 && o_normal_y == 0))
        else $error("miss result carries nonzero fields");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vo |-> o_ready)
        else $error("input stalled while output stage is empty");

    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vsq[SQ_N-1] |-> (sq_last.rem <= {1'b0, sq_last.root, 1'b0}))
        else $error("square root remainder out of range");

endmodule
